/* rtl/http_chunked_body_decoder_core_defines.svh */
// ----------------------------------------------------------------------------
// HTTP chunked body decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define HCBD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HCBD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/hcbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, constants and helpers for the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam int SIZE_BITS  = 24;
	localparam int TOTAL_BITS = 24;

	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_HT = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [1:0] TRAIL_LEN = 2'd2;

	typedef enum logic [2:0] {
		PH_SPACE  = 3'd0,
		PH_DIGITS = 3'd1,
		PH_EXT    = 3'd2,
		PH_DATA   = 3'd3,
		PH_TRAIL  = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       start_of_body;
	} hcbd_item_t;

	typedef struct packed {
		logic                  valid;
		logic [7:0]            payload_byte;
		logic                  is_end;
		logic [TOTAL_BITS-1:0] decoded_total;
	} hcbd_result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		case (c) inside
			[8'h30:8'h39]: h.value = c[3:0];
			[8'h41:8'h46],
			[8'h61:8'h66]: h.value = c[3:0] + 4'd9;
			default:       h.valid = 1'b0;
		endcase
		return h;
	endfunction

endpackage

/* rtl/hcbd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_parser
// Chunk framing state machine: one byte per step, at most one result.
// ----------------------------------------------------------------------------
module hcbd_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  hcbd_pkg::hcbd_item_t    item,
	output hcbd_pkg::hcbd_result_t  result
);

	localparam int SB = hcbd_pkg::SIZE_BITS;
	localparam int TB = hcbd_pkg::TOTAL_BITS;

	hcbd_pkg::phase_t phase_q, phase_d, cur_phase;
	logic [SB-1:0]    size_q, size_d, cur_size, acc_base;
	logic [SB-1:0]    rem_q, rem_d, cur_rem, rem_dec;
	logic             saw_cr_q, saw_cr_d, cur_saw_cr;
	logic [1:0]       trail_q, trail_d, cur_trail, trail_dec;
	logic [TB-1:0]    total_q, total_d, cur_total, total_inc;
	logic             sp_tab, is_cr, is_lf;
	hcbd_pkg::hex_t   hex;
	logic [7:0]       c;

	assign c          = item.body_byte;
	assign cur_phase  = item.start_of_body ? hcbd_pkg::PH_SPACE : phase_q;
	assign cur_size   = item.start_of_body ? '0 : size_q;
	assign cur_rem    = item.start_of_body ? '0 : rem_q;
	assign cur_saw_cr = item.start_of_body ? 1'b0 : saw_cr_q;
	assign cur_trail  = item.start_of_body ? 2'd0 : trail_q;
	assign cur_total  = item.start_of_body ? '0 : total_q;

	assign sp_tab    = (c == hcbd_pkg::CH_SP) || (c == hcbd_pkg::CH_HT);
	assign is_cr     = (c == hcbd_pkg::CH_CR);
	assign is_lf     = (c == hcbd_pkg::CH_LF);
	assign hex       = hcbd_pkg::hex_decode(c);
	assign acc_base  = (cur_phase == hcbd_pkg::PH_SPACE) ? '0 : cur_size;
	assign total_inc = (&cur_total) ? cur_total : cur_total + 1'b1;
	assign rem_dec   = (cur_rem != '0) ? cur_rem - 1'b1 : cur_rem;
	assign trail_dec = (cur_trail != 2'd0) ? cur_trail - 2'd1 : cur_trail;

	// next state
	always_comb begin
		phase_d  = cur_phase;
		size_d   = cur_size;
		rem_d    = cur_rem;
		saw_cr_d = cur_saw_cr;
		trail_d  = cur_trail;
		total_d  = cur_total;
		case (cur_phase)
			hcbd_pkg::PH_SPACE, hcbd_pkg::PH_DIGITS: begin
				if (!(cur_phase == hcbd_pkg::PH_SPACE && sp_tab)) begin
					phase_d = hcbd_pkg::PH_DIGITS;
					size_d  = acc_base;
					if (hex.valid) begin
						// saturate when the top nibble would shift out
						if (|acc_base[SB-1:SB-4]) size_d = '1;
						else                      size_d = {acc_base[SB-5:0], hex.value};
					end else if (acc_base == '0) begin
						phase_d = hcbd_pkg::PH_DONE;
					end else begin
						phase_d  = hcbd_pkg::PH_EXT;
						saw_cr_d = is_cr;
					end
				end
			end
			hcbd_pkg::PH_EXT: begin
				if (cur_saw_cr && is_lf) begin
					saw_cr_d = 1'b0;
					rem_d    = cur_size;
					phase_d  = hcbd_pkg::PH_DATA;
				end else begin
					saw_cr_d = is_cr;
				end
			end
			hcbd_pkg::PH_DATA: begin
				total_d = total_inc;
				rem_d   = rem_dec;
				if (rem_dec == '0) begin
					phase_d = hcbd_pkg::PH_TRAIL;
					trail_d = hcbd_pkg::TRAIL_LEN;
				end
			end
			hcbd_pkg::PH_TRAIL: begin
				trail_d = trail_dec;
				if (trail_dec == 2'd0) begin
					phase_d = hcbd_pkg::PH_SPACE;
					size_d  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// result
	always_comb begin
		result               = '0;
		result.decoded_total = cur_total;
		case (cur_phase)
			hcbd_pkg::PH_SPACE, hcbd_pkg::PH_DIGITS: begin
				if (!(cur_phase == hcbd_pkg::PH_SPACE && sp_tab) && !hex.valid
						&& acc_base == '0) begin
					result.valid  = 1'b1;
					result.is_end = 1'b1;
				end
			end
			hcbd_pkg::PH_DATA: begin
				result.valid         = 1'b1;
				result.payload_byte  = c;
				result.decoded_total = total_inc;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hcbd_pkg::PH_SPACE;
			size_q   <= '0;
			rem_q    <= '0;
			saw_cr_q <= 1'b0;
			trail_q  <= 2'd0;
			total_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			size_q   <= size_d;
			rem_q    <= rem_d;
			saw_cr_q <= saw_cr_d;
			trail_q  <= trail_d;
			total_q  <= total_d;
		end
	end

endmodule

/* rtl/http_chunked_body_decoder_core.sv */
`timescale 1ns / 1ps
// An input transaction passes the input register, then the result register.
// Throughput: one byte per cycle while the output side takes results.
// The limit is the single-byte framing state update in hcbd_parser.
// Reset (arst_n low, async) empties both stages and puts the parser in the
// leading-whitespace phase with all counters at zero.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Chunked transfer body decoder: input register, framing logic, result register.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_core_defines.svh"

module http_chunked_body_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
	input  logic        s_axis_tuser,   // [0] start_of_body
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [31:8] decoded_total
	output logic        m_axis_tuser    // [0] is_end
);

	logic                   valid_s1;
	hcbd_pkg::hcbd_item_t   item_s1;
	logic                   advance;
	hcbd_pkg::hcbd_result_t res;
	logic                   out_valid_s2;
	logic [7:0]             payload_s2;
	logic                   is_end_s2;
	logic [23:0]            total_s2;

	assign advance       = valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.body_byte     <= s_axis_tdata;
			item_s1.start_of_body <= s_axis_tuser;
		end
	end

	hcbd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= res.valid;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			payload_s2 <= res.payload_byte;
			is_end_s2  <= res.is_end;
			total_s2   <= res.decoded_total;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {total_s2, payload_s2};
	assign m_axis_tuser  = is_end_s2;

	`HCBD_ASSERT_IMP(a_end_zero_payload, out_valid_s2 && is_end_s2, payload_s2 == 8'd0, "end result with nonzero payload")
	`HCBD_ASSERT_IMP(a_data_total_nonzero, out_valid_s2 && !is_end_s2, total_s2 != 24'd0, "payload result with zero total")
	`HCBD_ASSERT_NXT(a_s1_held, valid_s1 && !advance, valid_s1 && $stable(item_s1), "stalled input stage lost its transaction")
	`HCBD_ASSERT_NXT(a_s2_held, out_valid_s2 && !m_axis_tready, out_valid_s2 && $stable(total_s2), "stalled result overwritten")

endmodule

/* bench/http_chunked_body_decoder_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core_tb
// Feeds chunked body bytes through the slave stream with random gaps and
// random result back-pressure. A local chunk decoder computes the payload and
// end transactions that each byte should cause, and every output transaction
// is checked field by field in order. The run starts with a short table of
// edge cases, then moves on to random bodies, broken bodies and noise.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core_tb;

	localparam int RANDOM_ITEMS = 1400;
	localparam int N_DIRECTED   = 30;

	typedef struct packed {
		logic [7:0]                      payload;
		logic                            is_end;
		logic [hcbd_pkg::TOTAL_BITS-1:0] total;
	} dec_out_t;

	typedef struct packed {
		logic [7:0] b;
		logic       sob;
		logic       fixed;
		dec_out_t   res;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] b;
		logic       sob;
	} feed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] body_byte
	logic        s_axis_tuser;   // [0] start_of_body
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [7:0] payload_byte, [31:8] decoded_total
	logic        m_axis_tuser;   // [0] is_end

	http_chunked_body_decoder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(8_000_000);
		$display("http_chunked_body_decoder_core_tb: done, errors");
		$finish;
	end

	// decoder state
	hcbd_pkg::phase_t                ph;
	logic [hcbd_pkg::SIZE_BITS-1:0]  size_acc;
	logic [hcbd_pkg::SIZE_BITS-1:0]  remain;
	logic                            cr_seen;
	logic [1:0]                      skip_left;
	logic [hcbd_pkg::TOTAL_BITS-1:0] body_total;

	dec_out_t due_results[$];
	feed_t    feed_q[$];
	int       mismatches = 0;
	int       live_items = 0;
	bit       pend_sob;
	bit       tx_calm, rx_calm;
	int       tx_left = 0, rx_left = 0;

	function automatic void clear_decoder();
		ph         = hcbd_pkg::PH_SPACE;
		size_acc   = '0;
		remain     = '0;
		cr_seen    = 1'b0;
		skip_left  = '0;
		body_total = '0;
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - 8'h30);
		if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
		if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
		return -1;
	endfunction

	function automatic bit decode_step(input logic [7:0] c, input logic sob,
			output dec_out_t r);
		logic [hcbd_pkg::SIZE_BITS+3:0] grown;
		int nib;
		r = '0;
		if (sob) clear_decoder();
		if (ph == hcbd_pkg::PH_SPACE) begin
			if (c == hcbd_pkg::CH_SP || c == hcbd_pkg::CH_HT) return 1'b0;
			size_acc = '0;
			ph = hcbd_pkg::PH_DIGITS;
		end
		case (ph)
			hcbd_pkg::PH_DIGITS: begin
				nib = hex_nibble(c);
				if (nib >= 0) begin
					grown = {size_acc, 4'b0000} + (hcbd_pkg::SIZE_BITS+4)'(nib);
					if (grown[hcbd_pkg::SIZE_BITS+3:hcbd_pkg::SIZE_BITS] != 4'd0)
						size_acc = '1;
					else size_acc = grown[hcbd_pkg::SIZE_BITS-1:0];
					return 1'b0;
				end
				if (size_acc == '0) begin
					ph = hcbd_pkg::PH_DONE;
					r.is_end = 1'b1;
					r.total = body_total;
					return 1'b1;
				end
				ph = hcbd_pkg::PH_EXT;
				cr_seen = (c == hcbd_pkg::CH_CR);
				return 1'b0;
			end
			hcbd_pkg::PH_EXT: begin
				if (cr_seen && c == hcbd_pkg::CH_LF) begin
					cr_seen = 1'b0;
					remain = size_acc;
					ph = hcbd_pkg::PH_DATA;
				end else begin
					cr_seen = (c == hcbd_pkg::CH_CR);
				end
				return 1'b0;
			end
			hcbd_pkg::PH_DATA: begin
				if (body_total != '1) body_total++;
				if (remain != '0) remain--;
				if (remain == '0) begin
					ph = hcbd_pkg::PH_TRAIL;
					skip_left = hcbd_pkg::TRAIL_LEN;
				end
				r.payload = c;
				r.total = body_total;
				return 1'b1;
			end
			hcbd_pkg::PH_TRAIL: begin
				if (skip_left != '0) skip_left--;
				if (skip_left == '0) begin
					ph = hcbd_pkg::PH_SPACE;
					size_acc = '0;
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// wait length per transaction, with calm stretches of no idling
	function automatic int draw_wait(inout bit calm, inout int left);
		if (left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			left = $urandom_range(20, 80);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	// directed: byte, start_of_body, fixed expectation, {payload, is_end, total}
	stim_row_t directed [N_DIRECTED] = '{
		'{"0",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},   // no start after reset
		'{hcbd_pkg::CH_CR, 1'b0, 1'b1, '{8'h00, 1'b1, 24'd0}},
		'{"Z",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},   // ignored after end
		'{hcbd_pkg::CH_SP, 1'b1, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{hcbd_pkg::CH_HT, 1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"2",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{";",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"x",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{hcbd_pkg::CH_CR, 1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{hcbd_pkg::CH_LF, 1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{8'h00,           1'b0, 1'b1, '{8'h00, 1'b0, 24'd1}},   // NUL payload
		'{8'hFF,           1'b0, 1'b1, '{8'hFF, 1'b0, 24'd2}},
		'{hcbd_pkg::CH_CR, 1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{hcbd_pkg::CH_LF, 1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"-",             1'b0, 1'b1, '{8'h00, 1'b1, 24'd2}},   // sign, no digits
		'{"0",             1'b1, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"x",             1'b0, 1'b1, '{8'h00, 1'b1, 24'd0}},   // 0x prefix
		'{"F",             1'b1, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"f",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"A",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"a",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"9",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"F",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{"B",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},   // size saturates
		'{"+",             1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{hcbd_pkg::CH_LF, 1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},   // LF without CR
		'{hcbd_pkg::CH_CR, 1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{hcbd_pkg::CH_LF, 1'b0, 1'b0, '{8'h00, 1'b0, 24'd0}},
		'{8'h80,           1'b0, 1'b1, '{8'h80, 1'b0, 24'd1}},
		'{hcbd_pkg::CH_LF, 1'b1, 1'b1, '{8'h00, 1'b1, 24'd0}}    // restart mid chunk
	};

	function automatic void put(input logic [7:0] b);
		feed_q.push_back('{b, pend_sob});
		pend_sob = 1'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic void put_size(input int unsigned sz);
		logic [3:0] nibs[$];
		int unsigned v;
		int lead;
		v = sz;
		do begin
			nibs.push_front(v[3:0]);
			v = v >> 4;
		end while (v != 0);
		lead = $urandom_range(0, 2);
		repeat (lead) nibs.push_front(4'h0);
		foreach (nibs[i]) put(hex_char(nibs[i]));
	endfunction

	function automatic void put_blanks();
		int n;
		n = $urandom_range(0, 2);
		repeat (n) put($urandom_range(0, 1) ? hcbd_pkg::CH_SP : hcbd_pkg::CH_HT);
	endfunction

	task automatic make_traffic();
		int kind, n, chunks, sz, cut;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			n = $urandom_range(1, 20);
			repeat (n) begin
				pend_sob = ($urandom_range(0, 7) == 0);
				put(8'($urandom_range(0, 255)));
			end
			return;
		end
		pend_sob = 1'b1;
		chunks = $urandom_range(0, 3);
		repeat (chunks) begin
			put_blanks();
			sz = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
			put_size(sz);
			if ($urandom_range(0, 2) == 0) begin
				put(";");
				n = $urandom_range(0, 4);
				repeat (n) put(8'($urandom_range(0, 255)));
			end
			put(hcbd_pkg::CH_CR);
			put(hcbd_pkg::CH_LF);
			repeat (sz) put(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) != 0) begin
				put(hcbd_pkg::CH_CR);
				put(hcbd_pkg::CH_LF);
			end else begin
				put(8'($urandom_range(0, 255)));
				put(8'($urandom_range(0, 255)));
			end
		end
		put_blanks();
		if ($urandom_range(0, 7) != 0) put_size(0);
		put(hcbd_pkg::CH_CR);
		put(hcbd_pkg::CH_LF);
		put(hcbd_pkg::CH_CR);
		put(hcbd_pkg::CH_LF);
		n = $urandom_range(0, 3);
		repeat (n) put(8'($urandom_range(0, 255)));
		if (kind == 9) begin
			cut = $urandom_range(1, feed_q.size());
			feed_q = feed_q[0:cut-1];
		end
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input logic [7:0] b, input logic sob, input logic fixed,
			input dec_out_t fres);
		int gap;
		bit got;
		dec_out_t pred;
		gap = draw_wait(tx_calm, tx_left);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= sob;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		live_items++;
		got = decode_step(b, sob, pred);
		if (fixed) due_results.push_back(fres);
		else if (got) due_results.push_back(pred);
		@(negedge clk);
	endtask

	initial begin : rx_side
		int hold;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			hold = draw_wait(rx_calm, rx_left);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		dec_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected transaction, payload %h is_end %b total %0d",
					$time, m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[31:8]);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (m_axis_tdata[7:0] !== want.payload) begin
					$display("%0t: payload_byte expected %h, got %h",
						$time, want.payload, m_axis_tdata[7:0]);
					mismatches++;
				end
				if (m_axis_tuser !== want.is_end) begin
					$display("%0t: is_end expected %b, got %b",
						$time, want.is_end, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[31:8] !== want.total) begin
					$display("%0t: decoded_total expected %0d, got %0d",
						$time, want.total, m_axis_tdata[31:8]);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		feed_t f;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tuser  = 1'b0;
		clear_decoder();
		wait (arst_n === 1'b1);
		@(negedge clk);
		foreach (directed[i])
			send_item(directed[i].b, directed[i].sob, directed[i].fixed, directed[i].res);
		while (live_items < N_DIRECTED + RANDOM_ITEMS) begin
			if (feed_q.size() == 0) make_traffic();
			f = feed_q.pop_front();
			send_item(f.b, f.sob, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("http_chunked_body_decoder_core_tb: done, clean");
		end else begin
			$display("http_chunked_body_decoder_core_tb: done, errors");
		end
		$finish;
	end

endmodule
